@@ rtl/core/des_pkg.sv @@
// Shared types for the descending exchange sort block.
// Holds the record and emit word layouts used by the sequencer and the top level.
// No dependencies.
`timescale 1ns / 1ps

package des_pkg;

   localparam int SCORE_W = 16;
   localparam int TAG_W   = 8;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } record_type;

   typedef struct packed {
      logic       valid;
      record_type rec;
      logic       final_result;
      logic       overflow;
   } emit_type;

endpackage

@@ rtl/core/des_if.sv @@
// Channel interfaces for the descending exchange sort block.
// des_req_if carries input records, des_rsp_if carries sorted results.
// Depends on des_pkg.
`timescale 1ns / 1ps

interface des_req_if;
   import des_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [SCORE_W-1:0] score;
   logic [TAG_W-1:0]          tag;
   logic                      final_record;

   modport source (output valid, output score, output tag, output final_record, input ready);
   modport sink   (input valid, input score, input tag, input final_record, output ready);
endinterface

interface des_rsp_if;
   import des_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [SCORE_W-1:0] sorted_score;
   logic [TAG_W-1:0]          sorted_tag;
   logic                      final_result;
   logic                      overflow;

   modport source (output valid, output sorted_score, output sorted_tag,
                   output final_result, output overflow, input ready);
   modport sink   (input valid, input sorted_score, input sorted_tag,
                   input final_result, input overflow, output ready);
endinterface

@@ rtl/core/des_store.sv @@
// Record memory for the descending exchange sort block.
// One write port and one registered read port.
// Depends on des_pkg.
`timescale 1ns / 1ps

module des_store #(
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  des_pkg::record_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output des_pkg::record_type rd_data
);
   import des_pkg::*;

   record_type mem [DEPTH];
   record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/des_seq.sv @@
// Load and sort sequencer for the descending exchange sort block.
// Drives the record memory and one shared score comparator; emits position i after pass i.
// Depends on des_pkg, des_if.
`timescale 1ns / 1ps

module des_seq #(
   parameter int CAPACITY = 16,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                clock,
   input  logic                reset,
   des_req_if.sink             req,
   input  logic                slot_free,
   output des_pkg::emit_type   emit,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output des_pkg::record_type wr_data,
   output logic [AW-1:0]       rd_addr,
   input  des_pkg::record_type rd_data
);
   import des_pkg::*;

   typedef enum logic [2:0] {
      S_LOAD,
      S_FETCH,
      S_HOLD,
      S_SCAN,
      S_EMIT
   } state_type;

   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   state_type     state_ff;
   logic [CW-1:0] count_ff;
   logic          dropped_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] i_ff;
   logic [CW-1:0] j_ff;
   record_type    holder_ff;

   logic [CW-1:0] i_in;
   logic [CW-1:0] j_in;
   logic          room;
   logic          greater;

   assign i_in    = i_ff + 1'b1;
   assign j_in    = j_ff + 1'b1;
   assign room    = (count_ff < CAP);
   // The one comparator: the record just read against the record held for position i.
   assign greater = ($signed(rd_data.score) > $signed(holder_ff.score));

   always_comb begin
      req.ready = (state_ff == S_LOAD);
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_data   = '{score: req.score, tag: req.tag};
      rd_addr   = i_ff[AW-1:0];
      unique case (state_ff)
         S_LOAD: begin
            wr_en = req.valid && room;
         end
         S_FETCH: begin
            rd_addr = i_ff[AW-1:0];
         end
         S_HOLD: begin
            rd_addr = i_in[AW-1:0];
         end
         S_SCAN: begin
            rd_addr = j_in[AW-1:0];
            // On a swap the displaced record goes back to position j.
            if (greater) begin
               wr_en   = 1'b1;
               wr_addr = j_ff[AW-1:0];
               wr_data = holder_ff;
            end
         end
         S_EMIT: begin
            rd_addr = i_ff[AW-1:0];
         end
         default: begin
            rd_addr = i_ff[AW-1:0];
         end
      endcase
   end

   always_comb begin
      emit.valid        = (state_ff == S_EMIT);
      emit.rec          = holder_ff;
      emit.final_result = (i_in == n_ff);
      emit.overflow     = dropped_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD: begin
               if (req.valid) begin
                  if (room) begin
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     dropped_ff <= 1'b1;
                  end
                  if (req.final_record) begin
                     n_ff     <= room ? count_ff + 1'b1 : count_ff;
                     i_ff     <= '0;
                     state_ff <= S_FETCH;
                  end
               end
            end
            S_FETCH: begin
               state_ff <= S_HOLD;
            end
            S_HOLD: begin
               holder_ff <= rd_data;
               j_ff      <= i_in;
               state_ff  <= (i_in == n_ff) ? S_EMIT : S_SCAN;
            end
            S_SCAN: begin
               if (greater) begin
                  holder_ff <= rd_data;
               end
               j_ff <= j_in;
               if (j_in == n_ff) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               // Position i is final once its pass ends, so it leaves straight from the holder.
               if (slot_free) begin
                  i_ff <= i_in;
                  if (i_in == n_ff) begin
                     count_ff   <= '0;
                     dropped_ff <= 1'b0;
                     state_ff   <= S_LOAD;
                  end else begin
                     state_ff <= S_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end

endmodule

@@ rtl/core/descending_exchange_sort.sv @@
// Top level of the descending exchange sort block.
// Connects the sequencer, the record memory and the result output register.
// Depends on des_pkg, des_if, des_store, des_seq.
//
//   Channel   Direction  Word
//   req_port  in         score, tag, final_record
//   rsp_port  out        sorted_score, sorted_tag, final_result, overflow
//
// Records load at one per cycle while the block waits for a set. A word with
// final_record set starts the sort; req_port.ready stays low until every result
// of the set has entered the output register. Pass i over n records runs the fetch and
// hold states, a scan of records i+1 to n-1 on the one memory read port and comparator,
// and the emit state, which waits while the output register is full and rsp_port.ready
// is held low. Reset is synchronous and empties the set.
`timescale 1ns / 1ps

module descending_exchange_sort #(
   parameter int CAPACITY = 16
) (
   input  logic      clock,
   input  logic      reset,
   des_req_if.sink   req_port,
   des_rsp_if.source rsp_port
);
   import des_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   record_type    wr_data;
   logic [AW-1:0] rd_addr;
   record_type    rd_data;
   emit_type      emit;
   logic          slot_free;

   logic          rsp_valid_ff;
   emit_type      rsp_word_ff;

   des_seq #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req_port),
      .slot_free (slot_free),
      .emit      (emit),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   des_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff <= emit.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && emit.valid) begin
         rsp_word_ff <= emit;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.sorted_score = rsp_word_ff.rec.score;
   assign rsp_port.sorted_tag   = rsp_word_ff.rec.tag;
   assign rsp_port.final_result = rsp_word_ff.final_result;
   assign rsp_port.overflow     = rsp_word_ff.overflow;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for descending_exchange_sort: sends sets of (score, tag) words
// and compares every sorted result against an in-bench ranking model.
// Depends on des_pkg, des_if and the RTL of descending_exchange_sort.
`timescale 1ns / 1ps

module testbench;
   import des_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_ITEMS = 212;
   localparam int MAX_GAP      = 5;
   localparam int HOLD_AT      = 30;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 200000;

   localparam int FLAVOR_WIDE  = 0;
   localparam int FLAVOR_TIES  = 1;
   localparam int FLAVOR_EDGES = 2;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
      logic                      last;
      logic                      dropped;
   } ranked_word_type;

   typedef struct {
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
      bit                        last;
      bit                        typed;
      logic signed [SCORE_W-1:0] want_score;
      logic [TAG_W-1:0]          want_tag;
   } stim_row_type;

   localparam int DIRECTED_N = 18;

   // Typed rows are single-word sets sent from an empty block, so the result is the word itself.
   stim_row_type directed_rows[DIRECTED_N] = '{
      '{ 32767, 8'hFF, 1, 1,  32767, 8'hFF},
      '{-32768, 8'h00, 1, 1, -32768, 8'h00},
      '{     0, 8'h5A, 1, 1,      0, 8'h5A},
      '{    -1, 8'hA5, 1, 1,     -1, 8'hA5},
      '{     7, 8'h01, 0, 0,      0, 8'h00},
      '{     7, 8'h02, 0, 0,      0, 8'h00},
      '{    -7, 8'h03, 0, 0,      0, 8'h00},
      '{     7, 8'h04, 1, 0,      0, 8'h00},
      '{-32768, 8'h10, 0, 0,      0, 8'h00},
      '{    -1, 8'h11, 0, 0,      0, 8'h00},
      '{     0, 8'h12, 0, 0,      0, 8'h00},
      '{     1, 8'h13, 0, 0,      0, 8'h00},
      '{ 32767, 8'h14, 1, 0,      0, 8'h00},
      '{   300, 8'h20, 0, 0,      0, 8'h00},
      '{   200, 8'h21, 0, 0,      0, 8'h00},
      '{   100, 8'h22, 1, 0,      0, 8'h00},
      '{     0, 8'h30, 0, 0,      0, 8'h00},
      '{     0, 8'h31, 1, 0,      0, 8'h00}
   };

   logic clock;
   logic reset;
   int   cycle_count;
   int   mismatch_count;

   des_req_if req_bus();
   des_rsp_if rsp_bus();

   descending_exchange_sort #(.CAPACITY(CAPACITY)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // Ranking model state: the records held for the current set.
   record_type      held[CAPACITY];
   int              held_count;
   bit              held_dropped;
   ranked_word_type ranked_expect[$];

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t: %s", $time, what);
   endtask

   // Stores one accepted word; a word marked last ranks the held set and, when emit is set, queues the results.
   function automatic void take_record(input record_type rec, input bit last, input bit emit);
      record_type swap;
      int         n;
      if (held_count < CAPACITY) begin
         held[held_count] = rec;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (!last)
         return;
      n = held_count;
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            if ($signed(held[j].score) > $signed(held[i].score)) begin
               swap    = held[i];
               held[i] = held[j];
               held[j] = swap;
            end
         end
      end
      if (emit) begin
         for (int k = 0; k < n; k++)
            ranked_expect.push_back('{held[k].score, held[k].tag, k == n - 1, held_dropped});
      end
      held_count   = 0;
      held_dropped = 1'b0;
   endfunction

   task automatic send_word(input record_type rec, input bit last, input bit burst,
                            input bit typed, input ranked_word_type want);
      int gap;
      gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.score        <= rec.score;
      req_bus.tag          <= rec.tag;
      req_bus.final_record <= last;
      do @(posedge clock); while (!req_bus.ready);
      take_record(rec, last, !typed);
      if (typed)
         ranked_expect.push_back(want);
   endtask

   function automatic logic signed [SCORE_W-1:0] draw_score(input int flavor);
      unique case (flavor)
         FLAVOR_TIES: return SCORE_W'($urandom_range(0, 6) - 3);
         FLAVOR_EDGES: begin
            unique case ($urandom_range(0, 4))
               0: return SCORE_W'(-32768);
               1: return SCORE_W'(32767);
               2: return SCORE_W'(-1);
               3: return SCORE_W'(0);
               default: return SCORE_W'(1);
            endcase
         end
         default: return SCORE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic check_result();
      ranked_word_type want;
      if (ranked_expect.size() == 0) begin
         report_mismatch($sformatf("unexpected word: score %0d tag %02h",
                                   rsp_bus.sorted_score, rsp_bus.sorted_tag));
         return;
      end
      want = ranked_expect.pop_front();
      if (rsp_bus.sorted_score !== want.score)
         report_mismatch($sformatf("sorted_score %0d, expected %0d",
                                   rsp_bus.sorted_score, want.score));
      if (rsp_bus.sorted_tag !== want.tag)
         report_mismatch($sformatf("sorted_tag %02h, expected %02h",
                                   rsp_bus.sorted_tag, want.tag));
      if (rsp_bus.final_result !== want.last)
         report_mismatch($sformatf("final_result %b, expected %b",
                                   rsp_bus.final_result, want.last));
      if (rsp_bus.overflow !== want.dropped)
         report_mismatch($sformatf("overflow %b, expected %b", rsp_bus.overflow, want.dropped));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         check_result();
   end

   // Result side: random stalls, quiet stretches and one long hold that backs up the input.
   initial begin
      int taken;
      int stall;
      int quiet;
      taken = 0;
      quiet = 0;
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (taken == HOLD_AT) begin
            stall = HOLD_CYCLES;
         end else if (quiet > 0) begin
            stall = 0;
            quiet--;
         end else if ($urandom_range(0, 9) == 0) begin
            stall = 0;
            quiet = 24;
         end else begin
            stall = $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         taken++;
      end
   end

   initial begin
      int              items_sent;
      int              set_index;
      int              set_size;
      int              flavor;
      int              pick;
      bit              burst;
      record_type      rec;
      ranked_word_type want;
      cycle_count          = 0;
      mismatch_count       = 0;
      held_count           = 0;
      held_dropped         = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.score        = '0;
      req_bus.tag          = '0;
      req_bus.final_record = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         rec  = '{directed_rows[r].score, directed_rows[r].tag};
         want = '{directed_rows[r].want_score, directed_rows[r].want_tag, 1'b1, 1'b0};
         send_word(rec, directed_rows[r].last, 1'b0, directed_rows[r].typed, want);
      end

      // Random sets: mostly small, a full set and a just-overflowing set first.
      items_sent = 0;
      set_index  = 0;
      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (set_index == 0)
            set_size = CAPACITY;
         else if (set_index == 1)
            set_size = CAPACITY + 1;
         else if (pick < 14)
            set_size = $urandom_range(1, 8);
         else if (pick < 17)
            set_size = $urandom_range(9, CAPACITY);
         else
            set_size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
         flavor = $urandom_range(FLAVOR_WIDE, FLAVOR_EDGES);
         burst  = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < set_size; k++) begin
            rec = '{draw_score(flavor), 8'($urandom_range(0, 255))};
            send_word(rec, k == set_size - 1, burst, 1'b0, '0);
         end
         items_sent += set_size;
         set_index++;
      end
      req_bus.valid <= 1'b0;

      while (ranked_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/des_pkg.sv
rtl/core/des_if.sv
rtl/core/des_store.sv
rtl/core/des_seq.sv
rtl/core/descending_exchange_sort.sv
verif/testbench.sv
